[rtl/core/pmct_pkg.sv]
// Package with the shared types, constants and helpers of the prescaled match/capture timer.
`default_nettype none
package pmct_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int REG_WIDTH   = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int IDX_WIDTH   = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_HALT  = 2'd2,
    ACT_CLEAR = 2'd3
  } pmct_action_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_FLAG   = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_RELOAD = 2'd3
  } pmct_mode_t;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_PRESCALE = 2'd0,
    REG_MATCH    = 2'd1,
    REG_MODE     = 2'd2,
    REG_EDGES    = 2'd3
  } pmct_reg_idx_t;

  localparam int FLAG_MATCH = 0;
  localparam int FLAG_CAP0  = 1;
  localparam int FLAG_CAP1  = 2;

  typedef struct packed {
    logic [2:0]   clear_mask;
    logic         capture_pin1;
    logic         capture_pin0;
    pmct_action_t action;
  } pmct_item_t;

  typedef struct packed {
    logic                 running;
    logic                 irq;
    logic [2:0]           pending_flags;
    logic [OUT_WIDTH-1:0] capture1_value;
    logic [OUT_WIDTH-1:0] capture0_value;
    logic [OUT_WIDTH-1:0] count_value;
  } pmct_result_t;

  function automatic logic [OUT_WIDTH-1:0] to_out(input logic [COUNT_WIDTH-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[OUT_WIDTH-1:0];
  endfunction

  function automatic logic edge_hit(input logic [1:0] edges, input logic prev,
                                    input logic now);
    logic rise;
    logic fall;
    rise = !prev && now;
    fall = prev && !now;
    return (edges[0] && rise) || (edges[1] && fall);
  endfunction

endpackage
`default_nettype wire

[rtl/core/prescaled_match_capture_timer.sv]
// Top level of the prescaled match/capture timer.
//
//  Channel  Direction  Signals                        Contents
//  s        in         s_tvalid s_tready s_tdata      pins and clear mask, action in s_tuser
//  m        out        m_tvalid m_tready m_tdata      counter, latches, flags, irq, running
//  cfg      in         cfg_we cfg_index cfg_data      prescale, match, mode, capture edges
//
// Every beat is registered, then applied to the timer state, and its result is
// loaded into the output register together with the state update.
// One beat per cycle is sustained unless the output stalls; the state update is the only loop.
// Reset is synchronous and clears timer state, configuration and both valid bits; no clearing pass.
// A stalled output holds the input stage, which then holds s_tready low.
`default_nettype none
module prescaled_match_capture_timer
  import pmct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // capture_pin0, capture_pin1, clear_mask
  input  wire logic [1:0]             s_tuser,   // action
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // count_value, capture0_value,
                                                 // capture1_value, pending_flags, irq, running
  input  wire logic                   cfg_we,
  input  wire logic [IDX_WIDTH-1:0]   cfg_index,
  input  wire logic [REG_WIDTH-1:0]   cfg_data
);

  logic         space;
  logic         item_valid;
  logic         go;
  pmct_item_t   item;
  pmct_result_t result_next;

  assign go = item_valid && space;

  pmct_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (space),
    .item_valid (item_valid),
    .item       (item)
  );

  pmct_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .go          (go),
    .item        (item),
    .result_next (result_next)
  );

  pmct_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (go),
    .result_next (result_next),
    .space       (space),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule
`default_nettype wire

[rtl/core/pmct_in_reg.sv]
// Input register stage that holds one accepted beat until the core takes it.
`default_nettype none
module pmct_in_reg
  import pmct_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,   // capture_pin0, capture_pin1, clear_mask
  input  wire logic [1:0]            s_tuser,   // action
  input  wire logic                  advance,
  output logic                       item_valid,
  output pmct_item_t                 item
);

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.action       <= pmct_action_t'(s_tuser);
      item.capture_pin0 <= s_tdata[0];
      item.capture_pin1 <= s_tdata[1];
      item.clear_mask   <= s_tdata[4:2];
    end
  end

endmodule
`default_nettype wire

[rtl/core/pmct_core.sv]
// Timer state, configuration registers and the single-pass update for one beat.
`default_nettype none
module pmct_core
  import pmct_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [IDX_WIDTH-1:0] cfg_index,
  input  wire logic [REG_WIDTH-1:0] cfg_data,
  input  wire logic                 go,
  input  wire pmct_item_t           item,
  output pmct_result_t              result_next
);

  logic [REG_WIDTH-1:0]   prescale;
  logic [REG_WIDTH-1:0]   match_value;
  pmct_mode_t             match_mode;
  logic [1:0]             capture_edges;

  logic [REG_WIDTH-1:0]   prescale_count, prescale_count_next;
  logic [COUNT_WIDTH-1:0] main_count, main_count_next;
  logic [COUNT_WIDTH-1:0] capture0_latch, capture0_latch_next;
  logic [COUNT_WIDTH-1:0] capture1_latch, capture1_latch_next;
  logic [2:0]             flag_bits, flag_bits_next;
  logic                   enable_bit, enable_bit_next;
  logic [1:0]             prev_pins, prev_pins_next;
  logic [COUNT_WIDTH-1:0] count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale      <= '0;
      match_value   <= '0;
      match_mode    <= MODE_OFF;
      capture_edges <= '0;
    end else if (cfg_we) begin
      case (pmct_reg_idx_t'(cfg_index))
        REG_PRESCALE: prescale      <= cfg_data;
        REG_MATCH:    match_value   <= cfg_data;
        REG_MODE:     match_mode    <= pmct_mode_t'(cfg_data[1:0]);
        REG_EDGES:    capture_edges <= cfg_data[1:0];
        default:      ;
      endcase
    end
  end

  assign count_inc = main_count + COUNT_WIDTH'(1);

  always_comb begin
    prescale_count_next = prescale_count;
    main_count_next     = main_count;
    capture0_latch_next = capture0_latch;
    capture1_latch_next = capture1_latch;
    flag_bits_next      = flag_bits;
    enable_bit_next     = enable_bit;
    prev_pins_next      = prev_pins;
    case (item.action)
      ACT_TICK: begin
        if (edge_hit(capture_edges, prev_pins[0], item.capture_pin0)) begin
          capture0_latch_next       = main_count;
          flag_bits_next[FLAG_CAP0] = 1'b1;
        end
        if (edge_hit(capture_edges, prev_pins[1], item.capture_pin1)) begin
          capture1_latch_next       = main_count;
          flag_bits_next[FLAG_CAP1] = 1'b1;
        end
        prev_pins_next = {item.capture_pin1, item.capture_pin0};
        if (enable_bit) begin
          if (prescale_count >= prescale) begin
            prescale_count_next = '0;
            main_count_next     = count_inc;
            if (match_mode != MODE_OFF && 64'(count_inc) == 64'(match_value)) begin
              flag_bits_next[FLAG_MATCH] = 1'b1;
              if (match_mode == MODE_STOP) begin
                enable_bit_next = 1'b0;
              end else if (match_mode == MODE_RELOAD) begin
                main_count_next = '0;
              end
            end
          end else begin
            prescale_count_next = prescale_count + REG_WIDTH'(1);
          end
        end
      end
      ACT_START: begin
        enable_bit_next = 1'b1;
      end
      ACT_HALT: begin
        enable_bit_next     = 1'b0;
        prescale_count_next = '0;
        main_count_next     = '0;
      end
      ACT_CLEAR: begin
        flag_bits_next = flag_bits & ~item.clear_mask;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      main_count     <= '0;
      capture0_latch <= '0;
      capture1_latch <= '0;
      flag_bits      <= '0;
      enable_bit     <= 1'b0;
      prev_pins      <= '0;
    end else if (go) begin
      prescale_count <= prescale_count_next;
      main_count     <= main_count_next;
      capture0_latch <= capture0_latch_next;
      capture1_latch <= capture1_latch_next;
      flag_bits      <= flag_bits_next;
      enable_bit     <= enable_bit_next;
      prev_pins      <= prev_pins_next;
    end
  end

  always_comb begin
    result_next.count_value    = to_out(main_count_next);
    result_next.capture0_value = to_out(capture0_latch_next);
    result_next.capture1_value = to_out(capture1_latch_next);
    result_next.pending_flags  = flag_bits_next;
    result_next.irq            = |flag_bits_next;
    result_next.running        = enable_bit_next;
  end

`ifndef SYNTHESIS
  a_start_only: assert property (@(posedge clk) disable iff (rst)
    $rose(enable_bit) |-> $past(go) && $past(item.action) == ACT_START)
    else $error("counter enabled without a start beat");

  a_flags_only_tick: assert property (@(posedge clk) disable iff (rst)
    (go && item.action != ACT_TICK) |=> (flag_bits & ~$past(flag_bits)) == 3'b000)
    else $error("flag set by a beat other than tick");

  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    (go && item.action == ACT_TICK && !enable_bit) |=> $stable(main_count))
    else $error("counter moved while stopped");

  a_no_beat_no_change: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(flag_bits) && $stable(enable_bit) && $stable(prescale_count))
    else $error("state changed without a beat");
`endif

endmodule
`default_nettype wire

[rtl/core/pmct_out_reg.sv]
// Result register that holds one beat on the master side until it is taken.
`default_nettype none
module pmct_out_reg
  import pmct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire pmct_result_t           result_next,
  output logic                        space,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  pmct_result_t result;

  assign space   = !m_tvalid || m_tready;
  assign m_tdata = OUT_TDATA_W'(result);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire
